// ----- rtl/core/ata_pkg.sv -----
// Shared types and constants of the averaged temperature alarm.
// Holds the window geometry, the register map and the alarm status struct.
// Depends on nothing.
`default_nettype none

package ata_pkg;

   localparam int WINDOW_LEN  = 32;
   localparam int WIN_SHIFT   = $clog2(WINDOW_LEN);
   localparam int POS_W       = WIN_SHIFT;
   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = SAMPLE_W + WIN_SHIFT;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd213;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEMP_ENABLE    = 8'd0,
      CSR_TEMP_THRESHOLD = 8'd1,
      CSR_POWER_ENABLE   = 8'd2
   } csr_index_type;

   typedef struct packed {
      logic temp_event;
      logic power_event;
      logic temp_latched;
      logic power_latched;
   } alarm_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/ata_window.sv -----
// Sample ring and running sum of the averaged temperature alarm.
// Produces the window average that includes the current request's sample.
// Depends on ata_pkg.
`default_nettype none

module ata_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  logic [ata_pkg::SAMPLE_W-1:0]  temp_sample,
   output logic [ata_pkg::SAMPLE_W-1:0]  average
);
   import ata_pkg::*;

   logic [SAMPLE_W-1:0]   ring_ff [WINDOW_LEN];
   logic [WINDOW_LEN-1:0] filled_ff, filled_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SAMPLE_W-1:0]   oldest;
   logic [SUM_W-1:0]      window_total;

   always_comb begin
      oldest       = filled_ff[pos_ff] ? ring_ff[pos_ff] : '0;
      window_total = sum_ff - SUM_W'(oldest) + SUM_W'(temp_sample);
      average      = window_total[WIN_SHIFT +: SAMPLE_W];
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      filled_in    = filled_ff;
      if (item_valid) begin
         sum_in            = window_total;
         filled_in[pos_ff] = 1'b1;
         if (pos_ff == POS_W'(WINDOW_LEN - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         pos_ff    <= '0;
         filled_ff <= '0;
      end else begin
         sum_ff    <= sum_in;
         pos_ff    <= pos_in;
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         ring_ff[pos_ff] <= temp_sample;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ata_alarm.sv -----
// Configuration registers and alarm latches of the averaged temperature alarm.
// Decides the alarm events of each request and applies register writes.
// Depends on ata_pkg.
`default_nettype none

module ata_alarm (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   input  logic [ata_pkg::SAMPLE_W-1:0]     average,
   input  logic                             power_fault,
   input  logic                             csr_write,
   input  logic [ata_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ata_pkg::CSR_DATA_W-1:0]   csr_data,
   output ata_pkg::alarm_status_type        status
);
   import ata_pkg::*;

   logic                temp_enable_ff, temp_enable_in;
   logic                power_enable_ff, power_enable_in;
   logic [SAMPLE_W-1:0] threshold_ff, threshold_in;
   logic                temp_latch_ff, temp_latch_in;
   logic                power_latch_ff, power_latch_in;
   logic                temp_fire;
   logic                power_fire;

   always_comb begin
      temp_fire  = temp_enable_ff & ~temp_latch_ff & (average >= threshold_ff);
      power_fire = power_enable_ff & ~power_latch_ff & power_fault;

      status.temp_event    = item_valid & temp_fire;
      status.power_event   = item_valid & power_fire;
      status.temp_latched  = temp_latch_ff | status.temp_event;
      status.power_latched = power_latch_ff | status.power_event;
   end

   always_comb begin
      temp_enable_in  = temp_enable_ff;
      power_enable_in = power_enable_ff;
      threshold_in    = threshold_ff;
      temp_latch_in   = temp_latch_ff | (item_valid & temp_fire);
      power_latch_in  = power_latch_ff | (item_valid & power_fire);
      if (csr_write) begin
         unique case (csr_index)
            CSR_TEMP_ENABLE: begin
               temp_enable_in = csr_data[0];
               temp_latch_in  = 1'b0;
            end
            CSR_TEMP_THRESHOLD: begin
               threshold_in = csr_data[SAMPLE_W-1:0];
            end
            CSR_POWER_ENABLE: begin
               power_enable_in = csr_data[0];
               power_latch_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_enable_ff  <= 1'b0;
         power_enable_ff <= 1'b0;
         threshold_ff    <= THRESHOLD_RESET;
         temp_latch_ff   <= 1'b0;
         power_latch_ff  <= 1'b0;
      end else begin
         temp_enable_ff  <= temp_enable_in;
         power_enable_ff <= power_enable_in;
         threshold_ff    <= threshold_in;
         temp_latch_ff   <= temp_latch_in;
         power_latch_ff  <= power_latch_in;
      end
   end

   // A latch can only be set by a request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(temp_latch_ff) |-> $past(item_valid))
      else $error("temperature latch set without a request");

   assert property (@(posedge clock) disable iff (reset)
      $rose(power_latch_ff) |-> $past(item_valid) && $past(power_fault))
      else $error("power latch set without a faulting request");

   assert property (@(posedge clock) disable iff (reset)
      status.temp_event |-> temp_enable_ff && !temp_latch_ff)
      else $error("temperature event while disarmed or latched");

   assert property (@(posedge clock) disable iff (reset)
      status.power_event |=> power_latch_ff || $past(csr_write))
      else $error("power event did not latch");

endmodule

`default_nettype wire

// ----- rtl/core/averaged_temperature_alarm.sv -----
// Top level of the averaged temperature alarm.
// Instantiates the sample window and the alarm unit and holds the response register.
// Depends on ata_pkg, ata_window and ata_alarm.
//
// Usage:
//   Requests carry a 16-bit temperature sample and a power-fault flag on req_*.
//   Each request yields exactly one response on rsp_*: the mean of the last 32
//   samples (unwritten entries count as zero), the two alarm events and the two
//   alarm latch states after that request.
//   The response is registered and appears in the cycle after acceptance. One
//   request is accepted every cycle while req_stall is low; the running sum is
//   updated by one add and one subtract in the accepting cycle, which sets that rate.
//   When the receiver stalls a pending response, req_stall rises in the same
//   cycle and the response holds until it is taken.
//   Registers are written through csr_* at any cycle (csr_ready is always high):
//   index 0 arms the temperature alarm and clears its latch, index 1 sets the
//   threshold, index 2 arms the power alarm and clears its latch.
//   Reset is synchronous and active high: the window reads as all zeros, both
//   latches and enables clear, the threshold returns to 213 and no response is
//   pending. The block can accept requests in the first cycle after reset.
`default_nettype none

module averaged_temperature_alarm (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ata_pkg::SAMPLE_W-1:0]     req_temp_sample,
   input  logic                             req_power_fault_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ata_pkg::SAMPLE_W-1:0]     rsp_average_temp,
   output logic                             rsp_temp_alarm_event,
   output logic                             rsp_power_alarm_event,
   output logic                             rsp_temp_alarm_latched,
   output logic                             rsp_power_alarm_latched,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ata_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ata_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ata_pkg::*;

   logic                 accept;
   logic                 csr_write;
   logic [SAMPLE_W-1:0]  average;
   alarm_status_type     status;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  average_ff;
   alarm_status_type     status_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   ata_window u_window (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (accept),
      .temp_sample (req_temp_sample),
      .average     (average)
   );

   ata_alarm u_alarm (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (accept),
      .average     (average),
      .power_fault (req_power_fault_in),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .status      (status)
   );

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         average_ff <= average;
         status_ff  <= status;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_average_temp        = average_ff;
   assign rsp_temp_alarm_event    = status_ff.temp_event;
   assign rsp_power_alarm_event   = status_ff.power_event;
   assign rsp_temp_alarm_latched  = status_ff.temp_latched;
   assign rsp_power_alarm_latched = status_ff.power_latched;

endmodule

`default_nettype wire
